### src/dba_pkg.sv
// Package for the disk block allocator.
// Holds field widths, the default disk size and the result status codes.
// No dependencies.
package dba_pkg;

  // Default number of blocks on the disk
  localparam int BLOCKS_DEF = 64;

  // Most results one request may produce
  localparam int MAX_RESULTS = 64;

  // Item field widths
  localparam int BLOCK_W  = 6;
  localparam int STATUS_W = 3;
  localparam int LEN_W    = 7;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_OCCUPIED = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_BOUNDS   = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_FEW      = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_ZERO     = 3'd4;

endpackage

### src/dba_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used for the block bitmap and the link table. No dependencies.
module dba_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read, holds while rd_en is low
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### src/disk_block_allocator_core.sv
// Disk block allocator: used-block bitmap in a 1-bit RAM, chain links in a second RAM.
// Failures (zero length, out of bounds, too few free) answer in the cycle after accept.
// Contiguous: up to len bitmap reads (one per cycle), then one granted block per cycle while not stalled.
// Scattered: bitmap is scanned one block per cycle from block 0, pausing while a grant
// waits on a stalled output. One item at a time; the bitmap read port sets the pace.
// Reset (sync, active low): a clearing pass writes BLOCKS bitmap entries, one per cycle.
module disk_block_allocator_core
  import dba_pkg::*;
#(
  parameter int BLOCKS = BLOCKS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  // request items
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_kind,
  input  logic [BLOCK_W-1:0]  in_start_block,
  input  logic [LEN_W-1:0]    in_length,
  // result items
  output logic                out_valid,
  input  logic                out_stall,
  output logic [BLOCK_W-1:0]  out_block,
  output logic [STATUS_W-1:0] out_status,
  output logic                out_last
);

  localparam int AW = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
  localparam int BW = $clog2(BLOCKS + 1);
  localparam int SW = (BW > 8) ? BW : 8;

  // Sequencer states
  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_CHECK  = 3'd2;
  localparam logic [2:0] S_CWRITE = 3'd3;
  localparam logic [2:0] S_SCAT   = 3'd4;
  localparam logic [2:0] S_RESP   = 3'd5;

  // Block number from a bitmap address, low six bits
  function automatic logic [BLOCK_W-1:0] to_blk(input logic [AW-1:0] a);
    logic [SW-1:0] w;
    w = SW'(a);
    return w[BLOCK_W-1:0];
  endfunction

  // Bitmap address from a six-bit block number
  function automatic logic [AW-1:0] to_addr(input logic [BLOCK_W-1:0] b);
    logic [SW-1:0] w;
    w = SW'(b);
    return w[AW-1:0];
  endfunction

  logic [2:0]          state_r, state_nxt;
  logic [AW-1:0]       addr_r, addr_nxt;
  logic [AW-1:0]       eaddr_r, eaddr_nxt;
  logic [AW-1:0]       start_r, start_nxt;
  logic                rv_r, rv_nxt;
  logic [LEN_W-1:0]    cnt_r, cnt_nxt;
  logic [LEN_W-1:0]    rd_left_r, rd_left_nxt;
  logic [LEN_W-1:0]    len_r, len_nxt;
  logic [BW-1:0]       free_r, free_nxt;
  logic [BLOCK_W-1:0]  tail_r, tail_nxt;
  logic                tail_valid_r, tail_valid_nxt;
  logic [STATUS_W-1:0] resp_r, resp_nxt;

  logic                out_valid_r;
  logic [BLOCK_W-1:0]  out_block_r;
  logic [STATUS_W-1:0] out_status_r;
  logic                out_last_r;

  logic                emit;
  logic [BLOCK_W-1:0]  em_block;
  logic [STATUS_W-1:0] em_status;
  logic                em_last;

  logic                u_we, u_wd, u_re, u_rd;
  logic [AW-1:0]       u_wa, u_ra;
  logic                l_we;
  logic [AW-1:0]       l_wa;
  logic [BLOCK_W-1:0]  l_wd;

  logic                out_free;
  logic                in_acc;
  logic                need;
  logic [SW-1:0]       end_ext;
  logic                len_big;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == S_IDLE) && out_free);
  assign in_acc   = in_valid && !in_stall;
  assign end_ext  = SW'(in_start_block) + SW'(in_length);
  assign len_big  = in_length > LEN_W'(MAX_RESULTS);
  assign need     = rv_r && !u_rd;

  // Sequencer: bitmap read-modify-write and result generation
  always_comb begin
    state_nxt      = state_r;
    addr_nxt       = addr_r;
    eaddr_nxt      = eaddr_r;
    start_nxt      = start_r;
    rv_nxt         = rv_r;
    cnt_nxt        = cnt_r;
    rd_left_nxt    = rd_left_r;
    len_nxt        = len_r;
    free_nxt       = free_r;
    tail_nxt       = tail_r;
    tail_valid_nxt = tail_valid_r;
    resp_nxt       = resp_r;
    emit           = 1'b0;
    em_block       = '0;
    em_status      = STAT_OK;
    em_last        = 1'b0;
    u_we           = 1'b0;
    u_wa           = addr_r;
    u_wd           = 1'b0;
    u_re           = 1'b0;
    u_ra           = addr_r;
    l_we           = 1'b0;
    l_wa           = to_addr(tail_r);
    l_wd           = '0;

    unique case (state_r)
      S_CLEAR: begin
        u_we = 1'b1;
        if (addr_r == AW'(BLOCKS - 1)) begin
          addr_nxt  = '0;
          state_nxt = S_IDLE;
        end else begin
          addr_nxt = addr_r + AW'(1);
        end
      end

      S_IDLE: begin
        if (in_acc) begin
          if (in_length == '0) begin
            emit      = 1'b1;
            em_status = STAT_ZERO;
            em_last   = 1'b1;
          end else if (!in_kind) begin
            if (len_big || (end_ext > SW'(BLOCKS))) begin
              emit      = 1'b1;
              em_status = STAT_BOUNDS;
              em_last   = 1'b1;
            end else begin
              start_nxt   = to_addr(in_start_block);
              addr_nxt    = to_addr(in_start_block);
              rd_left_nxt = in_length;
              cnt_nxt     = in_length;
              len_nxt     = in_length;
              rv_nxt      = 1'b0;
              state_nxt   = S_CHECK;
            end
          end else begin
            if (len_big || (SW'(free_r) < SW'(in_length))) begin
              emit      = 1'b1;
              em_status = STAT_FEW;
              em_last   = 1'b1;
            end else begin
              addr_nxt  = '0;
              cnt_nxt   = in_length;
              rv_nxt    = 1'b0;
              state_nxt = S_SCAT;
            end
          end
        end
      end

      // Read the requested range; any used block refuses the request
      S_CHECK: begin
        rv_nxt = (rd_left_r != '0);
        if (rd_left_r != '0) begin
          u_re        = 1'b1;
          addr_nxt    = addr_r + AW'(1);
          rd_left_nxt = rd_left_r - LEN_W'(1);
        end
        if (rv_r) begin
          if (u_rd) begin
            resp_nxt  = STAT_OCCUPIED;
            rv_nxt    = 1'b0;
            state_nxt = S_RESP;
          end else if (cnt_r == LEN_W'(1)) begin
            addr_nxt  = start_r;
            cnt_nxt   = len_r;
            rv_nxt    = 1'b0;
            state_nxt = S_CWRITE;
          end else begin
            cnt_nxt = cnt_r - LEN_W'(1);
          end
        end
      end

      // Mark the range used, one block per item
      S_CWRITE: begin
        if (out_free) begin
          emit     = 1'b1;
          em_block = to_blk(addr_r);
          em_last  = (cnt_r == LEN_W'(1));
          u_we     = 1'b1;
          u_wd     = 1'b1;
          free_nxt = free_r - BW'(1);
          addr_nxt = addr_r + AW'(1);
          cnt_nxt  = cnt_r - LEN_W'(1);
          if (cnt_r == LEN_W'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end

      // First-free scan: read ahead one block, grant free ones and link them
      S_SCAT: begin
        if (!need || out_free) begin
          if (need) begin
            emit           = 1'b1;
            em_block       = to_blk(eaddr_r);
            em_last        = (cnt_r == LEN_W'(1));
            u_we           = 1'b1;
            u_wa           = eaddr_r;
            u_wd           = 1'b1;
            l_we           = tail_valid_r;
            l_wd           = to_blk(eaddr_r);
            tail_nxt       = to_blk(eaddr_r);
            tail_valid_nxt = 1'b1;
            free_nxt       = free_r - BW'(1);
            cnt_nxt        = cnt_r - LEN_W'(1);
          end
          if (need && (cnt_r == LEN_W'(1))) begin
            rv_nxt    = 1'b0;
            state_nxt = S_IDLE;
          end else begin
            u_re      = 1'b1;
            eaddr_nxt = addr_r;
            addr_nxt  = addr_r + AW'(1);
            rv_nxt    = 1'b1;
          end
        end
      end

      S_RESP: begin
        if (out_free) begin
          emit      = 1'b1;
          em_status = resp_r;
          em_last   = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      addr_r       <= '0;
      rv_r         <= 1'b0;
      cnt_r        <= '0;
      rd_left_r    <= '0;
      free_r       <= BW'(BLOCKS);
      tail_r       <= '0;
      tail_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      addr_r       <= addr_nxt;
      rv_r         <= rv_nxt;
      cnt_r        <= cnt_nxt;
      rd_left_r    <= rd_left_nxt;
      free_r       <= free_nxt;
      tail_r       <= tail_nxt;
      tail_valid_r <= tail_valid_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    eaddr_r <= eaddr_nxt;
    start_r <= start_nxt;
    len_r   <= len_nxt;
    resp_r  <= resp_nxt;
    if (emit) begin
      out_block_r  <= em_block;
      out_status_r <= em_status;
      out_last_r   <= em_last;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_block  = out_block_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

  // Used-block bitmap, one bit per block
  dba_ram #(
    .WIDTH (1),
    .DEPTH (BLOCKS)
  ) u_used_ram (
    .clk     (clk),
    .wr_en   (u_we),
    .wr_addr (u_wa),
    .wr_data (u_wd),
    .rd_en   (u_re),
    .rd_addr (u_ra),
    .rd_data (u_rd)
  );

  // Next-block link table, written only
  dba_ram #(
    .WIDTH (BLOCK_W),
    .DEPTH (BLOCKS)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (l_we),
    .wr_addr (l_wa),
    .wr_data (l_wd),
    .rd_en   (1'b0),
    .rd_addr (l_wa),
    .rd_data ()
  );

endmodule
